### rtl/tasd_pkg.sv
// Shared types and constants for the three-axis accelerometer smoothing block.
package tasd_pkg;

  // Result field width: signed Q4.12 g.
  localparam int ACCEL_W = 16;
  // Acceleration width during conversion, with headroom for the offset and saturation.
  localparam int ACC_EXT_W = ACCEL_W + 2;

  // Configuration register widths and indexes.
  localparam int GAIN_W = 17;
  localparam int DB_W = 15;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEADBAND = 1'b1;

  // Gain of 1.0 in Q1.16 and register reset values.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd8192;
  localparam logic [DB_W-1:0] DB_RESET = 15'd410;

  // The gain multiply walks the 16 fraction bits of the gain four bits a cycle.
  localparam int GAIN_DIGIT_W = 4;
  localparam int GAIN_FRAC_W = 16;
  localparam int GAIN_DIGITS = GAIN_FRAC_W / GAIN_DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(GAIN_DIGITS);

  // Conversion constants: 1.5 V offset in Q4.12 g, and saturation limits.
  localparam logic signed [ACC_EXT_W-1:0] ACC_OFFSET = 18'sd20480;
  localparam logic signed [ACC_EXT_W-1:0] ACC_MAX = 18'sd32767;
  localparam logic signed [ACC_EXT_W-1:0] ACC_MIN = -18'sd32768;

  // Number of axes handled in turn for each transaction.
  localparam int NUM_AXES = 3;
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_CONV,
    ST_FIN,
    ST_OUT
  } tasd_state_t;

endpackage

### rtl/tasd_stream_if.sv
// Valid/ready stream interfaces for the sample and acceleration channels.
interface tasd_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic [SAMPLE_BITS-1:0] sample_z;

  modport source(output valid, output sample_x, output sample_y, output sample_z,
                 input ready);
  modport sink(input valid, input sample_x, input sample_y, input sample_z,
               output ready);
endinterface

interface tasd_out_if import tasd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source(output valid, output accel_x, output accel_y, output accel_z,
                 input ready);
  modport sink(input valid, input accel_x, input accel_y, input accel_z,
               output ready);
endinterface

### rtl/three_axis_accel_smoothing_deadband.sv
// Three-axis accelerometer low-pass filter, conversion to g and deadband.
//
//  Channel   Direction  Handshake        Payload
//  in_ch     sink       valid / ready    sample_x, sample_y, sample_z (SAMPLE_BITS each)
//  out_ch    source     valid / ready    accel_x, accel_y, accel_z (signed Q4.12)
//  cfg_*     write      cfg_we           cfg_idx, cfg_wdata
//
// Each transaction takes the axes one after another through a shared four-bit-digit gain
// multiplier, which is skipped when the gain is one or more, with a step each for
// difference, level update, scaling and deadband.
// A finished result sits in the output register while the next transaction is taken in;
// the last cycle of a transaction stretches while the previous result is still unaccepted.
// Synchronous reset clears the filter levels to zero and loads the register defaults.
module three_axis_accel_smoothing_deadband import tasd_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tasd_in_if.sink               in_ch,
  tasd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Level width, signed difference width, product width and scaling shift.
  localparam int LW = SAMPLE_BITS + FRAC_BITS;
  localparam int DW = LW + 1;
  localparam int PW = DW + GAIN_DIGIT_W + 1;
  localparam int NW = LW + 4;
  localparam int CONV_SHIFT = LW - 12;
  localparam logic [LW-1:0] LVL_MAX = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic [NW-1:0] CONV_RND = NW'(1) << (CONV_SHIFT - 1);

  tasd_state_t state_r, state_nxt;

  logic [AXIS_W-1:0]            axis_r;
  logic [DIGIT_CNT_W-1:0]       mul_cnt_r;
  logic [GAIN_W-1:0]            gain_r;
  logic [DB_W-1:0]              db_r;
  logic [LW-1:0]                lvl_r [NUM_AXES];
  logic [SAMPLE_BITS-1:0]       smp_r [NUM_AXES];
  logic signed [ACCEL_W-1:0]    res_r [NUM_AXES];
  logic signed [DW-1:0]         diff_r;
  logic signed [DW-1:0]         hi_r;
  logic [GAIN_FRAC_W-1:0]       gsh_r;
  logic [LW-1:0]                conv_lvl_r;
  logic [ACCEL_W-1:0]           q_r;
  logic                         out_valid_r;
  logic signed [ACCEL_W-1:0]    out_x_r;
  logic signed [ACCEL_W-1:0]    out_y_r;
  logic signed [ACCEL_W-1:0]    out_z_r;

  logic                         in_ready;
  logic                         in_take;
  logic                         out_load;
  logic                         gain_full;
  logic [LW-1:0]                target;
  logic signed [DW-1:0]         diff_w;
  logic [GAIN_DIGIT_W-1:0]      digit;
  logic signed [PW-1:0]         mul_sum;
  logic signed [DW-1:0]         hi_next;
  logic [LW-1:0]                new_lvl;
  logic [NW-1:0]                num_rnd;
  logic signed [ACC_EXT_W-1:0]  acc_raw;
  logic signed [ACC_EXT_W-1:0]  acc_sat;
  logic signed [ACC_EXT_W-1:0]  thr;
  logic                         in_band;
  logic signed [ACCEL_W-1:0]    acc_fin;

  // Handshake signals.
  assign in_ready     = (state_r == ST_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_take      = in_ch.valid && in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.accel_x = out_x_r;
  assign out_ch.accel_y = out_y_r;
  assign out_ch.accel_z = out_z_r;

  // Difference between the new sample and the level of the current axis.
  assign gain_full = (gain_r >= GAIN_ONE);
  assign target    = {smp_r[0], {FRAC_BITS{1'b0}}};
  assign diff_w    = $signed({1'b0, target}) - $signed({1'b0, lvl_r[0]});

  // One gain digit per cycle, least significant first; dropping four bits a step
  // leaves the floor of gain * diff / 65536 after the last digit.
  assign digit   = gsh_r[GAIN_DIGIT_W-1:0];
  assign mul_sum = $signed({{(PW-DW){hi_r[DW-1]}}, hi_r})
                 + $signed({{(PW-DW){diff_r[DW-1]}}, diff_r})
                 * $signed({{(PW-GAIN_DIGIT_W){1'b0}}, digit});
  assign hi_next = mul_sum[GAIN_DIGIT_W +: DW];

  // The step never leaves the span between old level and target, so modular add suffices.
  assign new_lvl = lvl_r[0] + hi_r[LW-1:0];

  // Level times 11, rounded, scaled to Q4.12 before the offset.
  assign num_rnd = {1'b0, conv_lvl_r, 3'b000} + {3'b000, conv_lvl_r, 1'b0}
                 + {4'b0000, conv_lvl_r} + CONV_RND;

  // Offset, saturation and deadband.
  assign acc_raw = $signed({2'b00, q_r}) - ACC_OFFSET;
  always_comb begin
    if (acc_raw > ACC_MAX) begin
      acc_sat = ACC_MAX;
    end else if (acc_raw < ACC_MIN) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_raw;
    end
  end
  assign thr     = $signed({3'b000, db_r});
  assign in_band = (acc_sat < thr) && (acc_sat > -thr);
  assign acc_fin = in_band ? '0 : acc_sat[ACCEL_W-1:0];

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_nxt = gain_full ? ST_UPD : ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt_r == DIGIT_CNT_W'(GAIN_DIGITS - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_CONV;
      end
      ST_CONV: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = (axis_r == AXIS_LAST) ? ST_OUT : ST_DIFF;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      db_r   <= DB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_GAIN:     gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_IDX_DEADBAND: db_r   <= cfg_wdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control counters, filter levels and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r      <= '0;
      mul_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lvl_r[i] <= '0;
      end
    end else begin
      if (state_r == ST_IDLE) begin
        axis_r <= '0;
      end else if (state_r == ST_FIN) begin
        axis_r <= axis_r + AXIS_W'(1);
      end
      if (state_r == ST_MUL) begin
        mul_cnt_r <= mul_cnt_r + DIGIT_CNT_W'(1);
      end else begin
        mul_cnt_r <= '0;
      end
      // Levels rotate so that the axis being worked on is always at the head.
      if (state_r == ST_UPD) begin
        lvl_r[0] <= lvl_r[1];
        lvl_r[1] <= lvl_r[2];
        lvl_r[2] <= new_lvl;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r[0] <= in_ch.sample_x;
      smp_r[1] <= in_ch.sample_y;
      smp_r[2] <= in_ch.sample_z;
    end else if (state_r == ST_UPD) begin
      smp_r[0] <= smp_r[1];
      smp_r[1] <= smp_r[2];
      smp_r[2] <= smp_r[0];
    end
    if (state_r == ST_DIFF) begin
      diff_r <= diff_w;
      gsh_r  <= gain_r[GAIN_FRAC_W-1:0];
      // A gain of one or more moves the level straight to the target.
      hi_r   <= gain_full ? diff_w : '0;
    end else if (state_r == ST_MUL) begin
      hi_r   <= hi_next;
      gsh_r  <= gsh_r >> GAIN_DIGIT_W;
    end
    if (state_r == ST_UPD) begin
      conv_lvl_r <= new_lvl;
    end
    if (state_r == ST_CONV) begin
      q_r <= num_rnd[CONV_SHIFT +: ACCEL_W];
    end
    // Results shift in so that x ends at the head after the third axis.
    if (state_r == ST_FIN) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
      res_r[2] <= acc_fin;
    end
    if (out_load) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

`ifndef SYNTHESIS
  // The sequencer leaves idle only when a transaction is taken.
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_take) |=> (state_r == ST_IDLE))
    else $error("sequencer left idle without an input transaction");

  // A free output register is loaded and the sequencer returns to idle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("result not presented after the last axis");

  // Filter levels never exceed the largest sample in fixed point.
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_r[0] <= LVL_MAX) && (lvl_r[1] <= LVL_MAX) && (lvl_r[2] <= LVL_MAX))
    else $error("filter level out of range");

  // The multiply runs exactly one digit per cycle and then updates the level.
  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mul_cnt_r == DIGIT_CNT_W'(GAIN_DIGITS - 1)) |=>
      (state_r == ST_UPD))
    else $error("gain multiply did not finish after the last digit");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the three-axis accelerometer smoothing and deadband block.
module tb_top;
  import tasd_pkg::*;

  localparam int SMP_W = 12;
  localparam int LVL_W = 28;
  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 92;
  localparam int N_DIR = 16;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } accel_t;

  // One row of the directed stimulus: optional register setup, samples, optional typed result.
  typedef struct {
    bit                 set_regs;
    logic [GAIN_W-1:0]  gain;
    logic [DB_W-1:0]    thr;
    logic [SMP_W-1:0]   sx;
    logic [SMP_W-1:0]   sy;
    logic [SMP_W-1:0]   sz;
    bit                 typed;
    accel_t             accel;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tasd_in_if #(.SAMPLE_BITS(SMP_W)) in_if ();
  tasd_out_if out_if ();

  three_axis_accel_smoothing_deadband #(
    .SAMPLE_BITS(SMP_W),
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the register file and the per-axis filter levels.
  logic [GAIN_W-1:0] gain_cur;
  logic [DB_W-1:0]   thr_cur;
  logic [LVL_W-1:0]  level_cur [3];

  accel_t   accel_exp_q [$];
  dir_row_t dir_tab [N_DIR];

  int  n_items;
  int  n_results;
  int  n_faults;
  int  n_cfg_writes;
  int  idle_cycles;
  int  out_hold;
  bit  in_idle_on;
  bit  out_idle_on;

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter one axis: update its level and return the deadbanded acceleration.
  function automatic logic signed [ACCEL_W-1:0] smooth_axis(input int a,
                                                            input logic [SMP_W-1:0] s);
    longint g;
    longint d;
    longint lvl;
    longint acc;
    longint th;
    g = (gain_cur > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_cur);
    d = (longint'(s) <<< FRAC) - longint'(level_cur[a]);
    lvl = longint'(level_cur[a]) + ((g * d) >>> 16);
    if (lvl < 0) lvl = 0;
    level_cur[a] = lvl[LVL_W-1:0];
    acc = ((longint'(level_cur[a]) * 11 + 32768) >>> 16) - 20480;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    th = longint'(thr_cur);
    if (acc < th && acc > -th) acc = 0;
    return acc[ACCEL_W-1:0];
  endfunction

  function automatic accel_t smooth_sample(input logic [SMP_W-1:0] sx, sy, sz);
    accel_t r;
    r.x = smooth_axis(0, sx);
    r.y = smooth_axis(1, sy);
    r.z = smooth_axis(2, sz);
    return r;
  endfunction

  // Draw one random sample: uniform, a small step from the last, an extreme, near 1862 or a repeat.
  function automatic logic [SMP_W-1:0] draw_sample(input logic [SMP_W-1:0] prev);
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        v = $urandom_range(0, 4095);
      end
      4, 5: begin
        v = int'(prev) + $urandom_range(0, 200) - 100;
      end
      6: begin
        v = $urandom_range(0, 1) ? 4095 : 0;
      end
      7, 8: begin
        v = 1862 + $urandom_range(0, 120) - 60;
      end
      default: begin
        v = int'(prev);
      end
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SMP_W-1:0];
  endfunction

  function automatic void log_fault(input string what, input accel_t exp_v, input accel_t got);
    n_faults++;
    if (n_faults <= 10) begin
      $display("ERROR result %0d: %s exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
               n_results, what, exp_v.x, exp_v.y, exp_v.z, got.x, got.y, got.z);
    end
  endfunction

  // Send one sample transaction and queue its expected acceleration.
  task automatic send_samples(input logic [SMP_W-1:0] sx, sy, sz,
                              input bit typed, input accel_t typed_val);
    int gap;
    accel_t pred;
    gap = in_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid    <= 1'b1;
    in_if.sample_x <= sx;
    in_if.sample_y <= sy;
    in_if.sample_z <= sz;
    do @(posedge clk); while (!in_if.ready);
    pred = smooth_sample(sx, sy, sz);
    accel_exp_q.push_back(typed ? typed_val : pred);
    n_items++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (accel_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_GAIN) gain_cur = val[GAIN_W-1:0];
    else thr_cur = val[DB_W-1:0];
    n_cfg_writes++;
  endtask

  task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [DB_W-1:0] thr);
    drain_results();
    write_reg(CFG_IDX_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_IDX_DEADBAND, CFG_DATA_W'(thr));
  endtask

  // Result ready: a random hold-off after each accepted transaction.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_if.ready <= 1'b0;
      out_hold--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    accel_t got;
    accel_t exp_v;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.x = out_if.accel_x;
      got.y = out_if.accel_y;
      got.z = out_if.accel_z;
      if (accel_exp_q.size() == 0) begin
        log_fault("unexpected transaction", '0, got);
      end else begin
        exp_v = accel_exp_q.pop_front();
        if (got.x !== exp_v.x) log_fault("accel_x differs", exp_v, got);
        if (got.y !== exp_v.y) log_fault("accel_y differs", exp_v, got);
        if (got.z !== exp_v.z) log_fault("accel_z differs", exp_v, got);
      end
      n_results++;
      out_hold = out_idle_on ? $urandom_range(0, 6) : 0;
    end
  end

  // Watchdog: end the run when no transaction or register write happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results still expected",
               IDLE_LIMIT, accel_exp_q.size());
      $display("three_axis_accel_smoothing_deadband: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    logic [SMP_W-1:0] px;
    logic [SMP_W-1:0] py;
    logic [SMP_W-1:0] pz;
    logic [GAIN_W-1:0] g;
    logic [DB_W-1:0] t;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.sample_x = '0;
    in_if.sample_y = '0;
    in_if.sample_z = '0;
    out_if.ready   = 1'b0;
    out_hold       = 0;
    idle_cycles    = 0;
    n_items        = 0;
    n_results      = 0;
    n_faults       = 0;
    n_cfg_writes   = 0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    gain_cur       = GAIN_RESET;
    thr_cur        = DB_RESET;
    foreach (level_cur[a]) level_cur[a] = '0;

    // Directed rows. With a gain of one the level equals the sample, so the
    // acceleration is 11 * sample - 20480 and can be typed in directly.
    dir_tab[0]  = '{1'b0, 17'd0, 15'd0, 12'd0, 12'd0, 12'd0, 1'b1,
                    '{-16'sd20480, -16'sd20480, -16'sd20480}};
    dir_tab[1]  = '{1'b0, 17'd0, 15'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0};
    dir_tab[2]  = '{1'b1, 17'd65536, 15'd410, 12'd4095, 12'd0, 12'd2048, 1'b1,
                    '{16'sd24565, -16'sd20480, 16'sd2048}};
    dir_tab[3]  = '{1'b0, 17'd0, 15'd0, 12'd0, 12'd4095, 12'd0, 1'b1,
                    '{-16'sd20480, 16'sd24565, -16'sd20480}};
    // Gain above one acts as one; deadband edge on the positive side.
    dir_tab[4]  = '{1'b1, 17'd131071, 15'd420, 12'd1900, 12'd1899, 12'd1900, 1'b1,
                    '{16'sd420, 16'sd0, 16'sd420}};
    // Deadband edge on the negative side.
    dir_tab[5]  = '{1'b1, 17'd131071, 15'd416, 12'd1824, 12'd1825, 12'd1823, 1'b1,
                    '{-16'sd416, 16'sd0, -16'sd427}};
    // A zero threshold disables the deadband.
    dir_tab[6]  = '{1'b1, 17'd131071, 15'd0, 12'd1862, 12'd1861, 12'd1863, 1'b1,
                    '{16'sd2, -16'sd9, 16'sd13}};
    // The largest threshold zeroes every output.
    dir_tab[7]  = '{1'b1, 17'd131071, 15'd32767, 12'd4095, 12'd0, 12'd2048, 1'b1,
                    '{16'sd0, 16'sd0, 16'sd0}};
    // A zero gain freezes the levels left by the previous row.
    dir_tab[8]  = '{1'b1, 17'd0, 15'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1,
                    '{16'sd24565, -16'sd20480, 16'sd2048}};
    dir_tab[9]  = '{1'b1, 17'd1, 15'd0, 12'd0, 12'd4095, 12'd0, 1'b0, '0};
    dir_tab[10] = '{1'b1, 17'd65535, 15'd410, 12'd1234, 12'd2345, 12'd3456, 1'b0, '0};
    dir_tab[11] = '{1'b1, 17'd8192, 15'd410, 12'hAAA, 12'h555, 12'hFFF, 1'b0, '0};
    dir_tab[12] = '{1'b0, 17'd0, 15'd0, 12'h555, 12'hAAA, 12'h000, 1'b0, '0};
    dir_tab[13] = '{1'b0, 17'd0, 15'd0, 12'd4095, 12'd0, 12'd4095, 1'b0, '0};
    dir_tab[14] = '{1'b0, 17'd0, 15'd0, 12'd0, 12'd4095, 12'd2048, 1'b0, '0};
    dir_tab[15] = '{1'b0, 17'd0, 15'd0, 12'd2048, 12'd2048, 12'd2048, 1'b0, '0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_regs) set_regs(dir_tab[i].gain, dir_tab[i].thr);
      send_samples(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].sz,
                   dir_tab[i].typed, dir_tab[i].accel);
    end

    // Random phases, each with its own register setting.
    px = SMP_W'(2048);
    py = SMP_W'(2048);
    pz = SMP_W'(2048);
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       g = '0;
        1:       g = GAIN_ONE;
        2:       g = GAIN_W'($urandom_range(65537, 131071));
        3:       g = GAIN_W'($urandom_range(1, 65535));
        default: g = GAIN_W'($urandom_range(2048, 20000));
      endcase
      case ($urandom_range(0, 5))
        0:       t = '0;
        1:       t = 15'd32767;
        2:       t = DB_W'($urandom_range(0, 32767));
        default: t = DB_W'($urandom_range(0, 3000));
      endcase
      set_regs(g, t);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 20 == 0) begin
          in_idle_on  = ($urandom_range(0, 3) != 0);
          out_idle_on = ($urandom_range(0, 3) != 0);
        end
        px = draw_sample(px);
        py = draw_sample(py);
        pz = draw_sample(pz);
        send_samples(px, py, pz, 1'b0, '0);
      end
    end

    // Let the last results come back, then a short quiet tail.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (accel_exp_q.size() != 0) begin
      n_faults++;
      $display("ERROR: %0d expected results never arrived", accel_exp_q.size());
    end

    $display("Sent %0d sample transactions, checked %0d results, %0d register writes.",
             n_items, n_results, n_cfg_writes);
    $display("Covered %0d random register settings; %0d errors found.", RAND_PHASES, n_faults);
    if (n_faults == 0) begin
      $display("three_axis_accel_smoothing_deadband: match");
    end else begin
      $display("three_axis_accel_smoothing_deadband: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tasd_pkg.sv
rtl/tasd_stream_if.sv
rtl/three_axis_accel_smoothing_deadband.sv
dv/tb_top.sv
